@@ design/lpc_pkg.sv @@
package lpc_pkg;

    localparam int QBITS = 30;

    // Q30 magnitude, one extra bit so that 1.0 and the largest coefficient fit
    typedef logic [QBITS:0] t_q30;

    localparam t_q30 Q_ONE  = 31'h4000_0000;
    localparam t_q30 Q_HALF = 31'h2000_0000;

    // quarter-wave sine polynomial, Horner order from the innermost term out
    localparam int   HORNER_STEPS = 6;
    localparam t_q30 POLY_A13     = 31'd61;
    localparam t_q30 POLY_COEF [HORNER_STEPS] = '{
        31'd3864,
        31'd172272,
        31'd5026995,
        31'd85569306,
        31'd693598668,
        31'd1686629713
    };

    // register stages from input register to the last lane stage
    localparam int PIPE_DEPTH = HORNER_STEPS + 3;

    localparam int STEP_BITS = 16;
    typedef logic [STEP_BITS-1:0] t_step;
    localparam t_step STEP_RESET = 16'd256;

    typedef enum logic [1:0] {
        SKID_EMPTY,
        SKID_ONE,
        SKID_FULL
    } t_skid_state;

    // Q30 multiply, rounded half up
    function automatic logic [31:0] qmul(input t_q30 a, input t_q30 b);
        logic [61:0] p;
        p = 62'(a) * 62'(b) + 62'(Q_HALF);
        return p[61:30];
    endfunction

endpackage

@@ design/lpc_trig_lane.sv @@
module lpc_trig_lane
    import lpc_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int RANGE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [1:0]                   i_quad,
    input  logic [ANGLE_BITS-3:0]        i_off,
    input  logic [RANGE_BITS-1:0]        i_range,
    output logic signed [RANGE_BITS:0]   o_coord
);

    localparam int OFF_BITS = ANGLE_BITS - 2;
    localparam int U_SHIFT  = QBITS - OFF_BITS;
    localparam logic [OFF_BITS:0] QUARTER = {1'b1, {OFF_BITS{1'b0}}};
    localparam int PROD_BITS = RANGE_BITS + QBITS + 1;

    // odd quadrants mirror the offset; a full quarter means exactly 1.0
    logic [OFF_BITS:0]  w_arg;
    logic               w_full;
    logic [QBITS-1:0]   w_u;
    logic [31:0]        w_u2_q;

    assign w_arg  = i_quad[0] ? (QUARTER - {1'b0, i_off}) : {1'b0, i_off};
    assign w_full = w_arg[OFF_BITS];
    assign w_u    = {w_arg[OFF_BITS-1:0], {U_SHIFT{1'b0}}};
    assign w_u2_q = qmul({1'b0, w_u}, {1'b0, w_u});

    logic [QBITS-1:0]      r_u    [HORNER_STEPS+1];
    logic                  r_full [HORNER_STEPS+1];
    logic                  r_neg  [HORNER_STEPS+2];
    logic [RANGE_BITS-1:0] r_rng  [HORNER_STEPS+2];
    logic [QBITS:0]        r_u2   [HORNER_STEPS];
    logic [QBITS:0]        r_acc  [HORNER_STEPS];
    logic [QBITS:0]        n_acc  [HORNER_STEPS];
    logic [QBITS:0]        r_coef;
    logic [QBITS:0]        n_coef;

    for (genvar h = 0; h < HORNER_STEPS; h++) begin : g_horner
        logic [QBITS:0] acc_in;
        logic [31:0]    prod_q;
        if (h == 0) begin : g_first
            assign acc_in = POLY_A13;
        end else begin : g_next
            assign acc_in = r_acc[h-1];
        end
        assign prod_q   = qmul(r_u2[h], acc_in);
        assign n_acc[h] = POLY_COEF[h] - prod_q[QBITS:0];
    end

    logic [31:0] w_sin_q;
    assign w_sin_q = qmul({1'b0, r_u[HORNER_STEPS]}, r_acc[HORNER_STEPS-1]);

    always_comb begin
        if (r_full[HORNER_STEPS] || (w_sin_q > 32'(Q_ONE))) begin
            n_coef = Q_ONE;
        end else begin
            n_coef = w_sin_q[QBITS:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u[0]    <= w_u;
            r_full[0] <= w_full;
            r_neg[0]  <= i_quad[1];
            r_rng[0]  <= i_range;
            r_u2[0]   <= w_u2_q[QBITS:0];
            for (int j = 1; j < HORNER_STEPS + 1; j++) begin
                r_u[j]    <= r_u[j-1];
                r_full[j] <= r_full[j-1];
            end
            for (int j = 1; j < HORNER_STEPS + 2; j++) begin
                r_neg[j] <= r_neg[j-1];
                r_rng[j] <= r_rng[j-1];
            end
            for (int j = 1; j < HORNER_STEPS; j++) begin
                r_u2[j] <= r_u2[j-1];
            end
            for (int h = 0; h < HORNER_STEPS; h++) begin
                r_acc[h] <= n_acc[h];
            end
            r_coef <= n_coef;
        end
    end

    // magnitude rounded half away from zero, sign applied afterwards
    logic [PROD_BITS-1:0]  w_prod;
    logic [RANGE_BITS:0]   w_mag;

    assign w_prod = PROD_BITS'(r_rng[HORNER_STEPS+1]) * PROD_BITS'(r_coef)
                  + PROD_BITS'(Q_HALF);
    assign w_mag  = {1'b0, w_prod[RANGE_BITS+QBITS-1:QBITS]};
    assign o_coord = r_neg[HORNER_STEPS+1] ? signed'(-w_mag) : signed'(w_mag);

endmodule

@@ design/lidar_polar_to_cartesian_unit.sv @@
// Lidar polar to cartesian converter.
// Input channel (i_valid / o_stall): one range sample per beat plus a scan_end
// flag. Output channel (o_valid / i_stall): one point per sample, x = range *
// sin(angle) and y = range * cos(angle), both rounded, with point_last copying
// scan_end. The scan angle starts at zero, advances by the angle step after
// each sample and returns to zero after a sample flagged scan_end.
// Config channel (i_cfg_valid / o_cfg_ready): writes the angle step; ready is
// always high. Write it only while no samples are in flight.
// Throughput: one sample per cycle while the output is not stalled. A sample
// taken into the input register then passes the u^2 stage, six Horner stages,
// the coefficient clamp stage and the output register, each fed by one multiplier per lane.
// When the receiver stalls, the output register holds its point and a second
// register absorbs the next one; then the whole pipeline freezes and o_stall
// rises until the receiver takes a beat. o_stall never depends on i_stall in
// the same cycle.
// Reset (synchronous, active low) empties the pipeline, zeroes the scan angle
// and sets the angle step to 256.
module lidar_polar_to_cartesian_unit
    import lpc_pkg::*;
#(
    parameter int RANGE_BITS = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [RANGE_BITS-1:0]       i_range_value,
    input  logic                        i_scan_end,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [RANGE_BITS:0]  o_x_coord,
    output logic signed [RANGE_BITS:0]  o_y_coord,
    output logic                        o_point_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [STEP_BITS-1:0]        i_cfg_angle_step
);

    localparam int SUM_BITS = (ANGLE_BITS > STEP_BITS) ? ANGLE_BITS : STEP_BITS;

    t_step                    r_step;
    logic [ANGLE_BITS-1:0]    r_scan_angle;
    logic [ANGLE_BITS-1:0]    n_scan_angle;
    logic [SUM_BITS-1:0]      w_sum;
    logic                     w_accept;
    logic                     w_en;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && w_en;
    assign w_sum       = SUM_BITS'(r_scan_angle) + SUM_BITS'(r_step);
    assign n_scan_angle = i_scan_end ? '0 : w_sum[ANGLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
        end else if (i_cfg_valid) begin
            r_step <= i_cfg_angle_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_angle <= '0;
        end else if (w_accept) begin
            r_scan_angle <= n_scan_angle;
        end
    end

    // input register
    logic [ANGLE_BITS-1:0]   r_s0_angle;
    logic [RANGE_BITS-1:0]   r_s0_range;
    logic [PIPE_DEPTH-1:0]   r_vld;
    logic [PIPE_DEPTH-1:0]   r_last;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_angle <= r_scan_angle;
            r_s0_range <= i_range_value;
            r_last     <= {r_last[PIPE_DEPTH-2:0], i_scan_end};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    // cos(a) = sin(a + quarter turn): same offset, next quadrant
    logic [1:0]                 w_quad_sin;
    logic [1:0]                 w_quad_cos;
    logic signed [RANGE_BITS:0] w_x;
    logic signed [RANGE_BITS:0] w_y;

    assign w_quad_sin = r_s0_angle[ANGLE_BITS-1 -: 2];
    assign w_quad_cos = w_quad_sin + 2'd1;

    lpc_trig_lane #(
        .ANGLE_BITS (ANGLE_BITS),
        .RANGE_BITS (RANGE_BITS)
    ) u_sin_lane (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_quad  (w_quad_sin),
        .i_off   (r_s0_angle[ANGLE_BITS-3:0]),
        .i_range (r_s0_range),
        .o_coord (w_x)
    );

    lpc_trig_lane #(
        .ANGLE_BITS (ANGLE_BITS),
        .RANGE_BITS (RANGE_BITS)
    ) u_cos_lane (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_quad  (w_quad_cos),
        .i_off   (r_s0_angle[ANGLE_BITS-3:0]),
        .i_range (r_s0_range),
        .o_coord (w_y)
    );

    // two-entry output buffer: output register plus skid register
    t_skid_state                r_state;
    t_skid_state                n_state;
    logic                       w_push;
    logic                       w_pop;
    logic signed [RANGE_BITS:0] r_out_x;
    logic signed [RANGE_BITS:0] r_out_y;
    logic                       r_out_last;
    logic signed [RANGE_BITS:0] r_skd_x;
    logic signed [RANGE_BITS:0] r_skd_y;
    logic                       r_skd_last;

    assign w_push = w_en && r_vld[PIPE_DEPTH-1];
    assign w_pop  = o_valid && !i_stall;

    always_comb begin
        case (r_state)
            SKID_EMPTY: begin
                n_state = w_push ? SKID_ONE : SKID_EMPTY;
            end
            SKID_ONE: begin
                if (w_push && !w_pop) begin
                    n_state = SKID_FULL;
                end else if (!w_push && w_pop) begin
                    n_state = SKID_EMPTY;
                end else begin
                    n_state = SKID_ONE;
                end
            end
            SKID_FULL: begin
                n_state = w_pop ? SKID_ONE : SKID_FULL;
            end
            default: begin
                n_state = SKID_EMPTY;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            SKID_EMPTY: begin
                o_valid = 1'b0;
                o_stall = 1'b0;
                w_en    = 1'b1;
            end
            SKID_ONE: begin
                o_valid = 1'b1;
                o_stall = 1'b0;
                w_en    = 1'b1;
            end
            SKID_FULL: begin
                o_valid = 1'b1;
                o_stall = 1'b1;
                w_en    = 1'b0;
            end
            default: begin
                o_valid = 1'b0;
                o_stall = 1'b1;
                w_en    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SKID_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            SKID_EMPTY: begin
                if (w_push) begin
                    r_out_x    <= w_x;
                    r_out_y    <= w_y;
                    r_out_last <= r_last[PIPE_DEPTH-1];
                end
            end
            SKID_ONE: begin
                if (w_push && w_pop) begin
                    r_out_x    <= w_x;
                    r_out_y    <= w_y;
                    r_out_last <= r_last[PIPE_DEPTH-1];
                end else if (w_push) begin
                    r_skd_x    <= w_x;
                    r_skd_y    <= w_y;
                    r_skd_last <= r_last[PIPE_DEPTH-1];
                end
            end
            SKID_FULL: begin
                if (w_pop) begin
                    r_out_x    <= r_skd_x;
                    r_out_y    <= r_skd_y;
                    r_out_last <= r_skd_last;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_x_coord    = r_out_x;
    assign o_y_coord    = r_out_y;
    assign o_point_last = r_out_last;

    ap_stall_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled while output buffer holds no point");

    ap_scan_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_scan_end) |=> (r_scan_angle == '0))
        else $error("scan angle not cleared after last sample of a scan");

    ap_full_needs_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SKID_FULL) |-> $past(i_stall))
        else $error("skid register filled without a receiver stall");

    ap_no_spurious_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(i_stall)) |-> !o_stall)
        else $error("input stalled although receiver took the last beat");

endmodule
